### hw/rtl/hstn_pkg.sv
// Shared types, constants and character tables of the HTML script-word neutralizer.
// No dependencies; used by the scanner, the output queue and the top level.
package hstn_pkg;

   localparam int WinDepth   = 5;
   localparam int WordLen    = WinDepth + 1;
   localparam int QueueDepth = 2 * WordLen;
   localparam int FillW      = $clog2(WinDepth + 1);
   localparam int PushCntW   = $clog2(WordLen + 1);
   localparam int QCntW      = $clog2(QueueDepth + 1);
   localparam int BeatIdxW   = $clog2(WordLen);

   localparam logic [7:0] LtChar   = 8'h3C;
   localparam logic [7:0] GtChar   = 8'h3E;
   localparam logic [7:0] SqChar   = 8'h27;
   localparam logic [7:0] DqChar   = 8'h22;
   localparam logic [7:0] CaseBit  = 8'h20;

   typedef logic [7:0] char_type;

   typedef struct packed {
      char_type data;
      logic     last;
   } beat_type;

   typedef struct packed {
      logic [PushCntW-1:0]         cnt;
      beat_type [WordLen-1:0]      beat;
   } push_type;

   // lower-case form of the word that gets neutralized
   function automatic char_type word_char(input logic [BeatIdxW-1:0] idx);
      char_type c;
      case (idx)
         3'd0:    c = 8'h73;   // s
         3'd1:    c = 8'h63;   // c
         3'd2:    c = 8'h72;   // r
         3'd3:    c = 8'h69;   // i
         3'd4:    c = 8'h70;   // p
         3'd5:    c = 8'h74;   // t
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // replacement text, space padded to the word length
   function automatic char_type span_char(input logic [BeatIdxW-1:0] idx);
      char_type c;
      case (idx)
         3'd0:    c = 8'h20;
         3'd1:    c = 8'h73;   // s
         3'd2:    c = 8'h70;   // p
         3'd3:    c = 8'h61;   // a
         3'd4:    c = 8'h6E;   // n
         3'd5:    c = 8'h20;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

### hw/rtl/hstn_scan.sv
// Scanner: lookahead window, tag/quote tracking and word match for one beat.
// Depends on hstn_pkg; emits up to six result beats per accepted input beat.
module hstn_scan (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  hstn_pkg::char_type       text_byte,
   input  logic                     end_of_text,
   output hstn_pkg::push_type       push
);

   logic                              in_tag_ff, in_tag_in;
   logic                              in_quote_ff, in_quote_in;
   hstn_pkg::char_type                quote_char_ff, quote_char_in;
   logic [hstn_pkg::FillW-1:0]        fill_ff, fill_in;
   hstn_pkg::char_type                win_ff [hstn_pkg::WinDepth];
   hstn_pkg::char_type                win_in [hstn_pkg::WinDepth];

   hstn_pkg::char_type                cand [hstn_pkg::WordLen];
   logic                              full_win;
   logic                              tag_t, quote_t;
   hstn_pkg::char_type                qchar_t;
   logic                              word_hit;
   logic                              rewrite;

   // candidate six bytes: window contents, then the new byte
   always_comb begin
      for (int i = 0; i < hstn_pkg::WordLen; i++) begin
         if (i < hstn_pkg::WinDepth && hstn_pkg::FillW'(i) < fill_ff) begin
            cand[i] = win_ff[(i < hstn_pkg::WinDepth) ? i : 0];
         end else begin
            cand[i] = text_byte;
         end
      end
   end

   assign full_win = (fill_ff == hstn_pkg::FillW'(hstn_pkg::WinDepth));

   // track the oldest byte
   always_comb begin
      tag_t   = in_tag_ff;
      quote_t = in_quote_ff;
      qchar_t = quote_char_ff;
      if (cand[0] == hstn_pkg::LtChar) begin
         tag_t = 1'b1;
      end
      if (cand[0] == hstn_pkg::GtChar && tag_t && !quote_t) begin
         tag_t = 1'b0;
      end
      if ((cand[0] == hstn_pkg::SqChar || cand[0] == hstn_pkg::DqChar) && tag_t) begin
         if (!quote_t) begin
            qchar_t = cand[0];
            quote_t = 1'b1;
         end else if (cand[0] == qchar_t) begin
            quote_t = 1'b0;
         end
      end
   end

   always_comb begin
      word_hit = 1'b1;
      for (int i = 0; i < hstn_pkg::WordLen; i++) begin
         if ((cand[i] | hstn_pkg::CaseBit) != hstn_pkg::word_char(hstn_pkg::BeatIdxW'(i))) begin
            word_hit = 1'b0;
         end
      end
   end

   assign rewrite = full_win && tag_t && !quote_t && word_hit;

   // result beats
   always_comb begin
      push.cnt = '0;
      for (int i = 0; i < hstn_pkg::WordLen; i++) begin
         push.beat[i].data = rewrite ? hstn_pkg::span_char(hstn_pkg::BeatIdxW'(i)) : cand[i];
         push.beat[i].last = end_of_text && (hstn_pkg::FillW'(i) == fill_ff);
      end
      if (accept) begin
         if (end_of_text) begin
            push.cnt = hstn_pkg::PushCntW'(fill_ff) + 1'b1;
         end else if (full_win) begin
            push.cnt = rewrite ? hstn_pkg::PushCntW'(hstn_pkg::WordLen) : hstn_pkg::PushCntW'(1);
         end
      end
   end

   // next state
   always_comb begin
      in_tag_in     = in_tag_ff;
      in_quote_in   = in_quote_ff;
      quote_char_in = quote_char_ff;
      fill_in       = fill_ff;
      for (int i = 0; i < hstn_pkg::WinDepth; i++) begin
         win_in[i] = win_ff[i];
      end
      if (accept) begin
         if (end_of_text) begin
            in_tag_in     = 1'b0;
            in_quote_in   = 1'b0;
            quote_char_in = '0;
            fill_in       = '0;
         end else if (!full_win) begin
            for (int i = 0; i < hstn_pkg::WinDepth; i++) begin
               if (hstn_pkg::FillW'(i) == fill_ff) begin
                  win_in[i] = text_byte;
               end
            end
            fill_in = fill_ff + 1'b1;
         end else begin
            in_tag_in     = tag_t;
            in_quote_in   = quote_t;
            quote_char_in = qchar_t;
            if (rewrite) begin
               fill_in = '0;
            end else begin
               for (int i = 0; i < hstn_pkg::WinDepth; i++) begin
                  win_in[i] = (i < hstn_pkg::WinDepth - 1) ?
                              win_ff[(i < hstn_pkg::WinDepth - 1) ? i + 1 : i] : text_byte;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_tag_ff     <= 1'b0;
         in_quote_ff   <= 1'b0;
         quote_char_ff <= '0;
         fill_ff       <= '0;
      end else begin
         in_tag_ff     <= in_tag_in;
         in_quote_ff   <= in_quote_in;
         quote_char_ff <= quote_char_in;
         fill_ff       <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < hstn_pkg::WinDepth; i++) begin
         win_ff[i] <= win_in[i];
      end
   end

endmodule

### hw/rtl/hstn_outq.sv
// Output queue: takes up to six beats per cycle, releases one per cycle when popped.
// Depends on hstn_pkg; the head entry is the registered result beat.
module hstn_outq (
   input  logic                 clock,
   input  logic                 reset,
   input  hstn_pkg::push_type   push,
   input  logic                 pop,
   output hstn_pkg::beat_type   head,
   output logic                 not_empty,
   output logic                 full
);

   hstn_pkg::beat_type          q_ff [hstn_pkg::QueueDepth];
   hstn_pkg::beat_type          q_in [hstn_pkg::QueueDepth];
   logic [hstn_pkg::QCntW-1:0]  cnt_ff, cnt_in;
   logic [hstn_pkg::QCntW-1:0]  base;
   logic [hstn_pkg::QCntW-1:0]  off [hstn_pkg::QueueDepth];

   assign base = cnt_ff - hstn_pkg::QCntW'(pop);

   // advance survivors, append new beats behind them
   always_comb begin
      for (int j = 0; j < hstn_pkg::QueueDepth; j++) begin
         off[j] = hstn_pkg::QCntW'(j) - base;
         if (hstn_pkg::QCntW'(j) < base) begin
            q_in[j] = pop ? q_ff[(j + 1 < hstn_pkg::QueueDepth) ? j + 1 : j] : q_ff[j];
         end else if (off[j] < hstn_pkg::QCntW'(push.cnt)) begin
            q_in[j] = push.beat[off[j][hstn_pkg::BeatIdxW-1:0]];
         end else begin
            q_in[j] = q_ff[j];
         end
      end
   end

   assign cnt_in    = base + hstn_pkg::QCntW'(push.cnt);
   assign head      = q_ff[0];
   assign not_empty = (cnt_ff != '0);
   assign full      = (cnt_ff > hstn_pkg::QCntW'(hstn_pkg::QueueDepth - hstn_pkg::WordLen));

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < hstn_pkg::QueueDepth; j++) begin
         q_ff[j] <= q_in[j];
      end
   end

endmodule

### hw/rtl/html_script_tag_neutralizer.sv
// Flow: a byte is decided once five later bytes have arrived or the beat that ends
//   the text arrives; its result beat is then registered in the output queue.
// Throughput: one input beat per cycle unless req_stall, one result beat per cycle
//   unless rsp_stall, from a 12-entry queue; req_stall rises above six queued beats.
// Reset: synchronous, active high; clears tag/quote tracking, the window fill and the
//   queue count. Window and queue contents are not cleared.
module html_script_tag_neutralizer (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_text_byte,
   input  logic                req_end_of_text,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_out_last
);

   logic                  accept;
   logic                  pop;
   logic                  q_full;
   logic                  q_not_empty;
   hstn_pkg::push_type    push;
   hstn_pkg::beat_type    head;

   // Hold off new input beats while the queue might not fit a full rewrite.
   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   // Result beat leaves when the receiver is not stalling.
   assign pop = rsp_valid && !rsp_stall;

   // The scanner holds up to five pending bytes and the tracking state. Per input
   // beat it produces nothing (window filling), the oldest byte, the " span "
   // rewrite, or, on the end of the text, every pending byte plus the new one.
   hstn_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .text_byte   (req_text_byte),
      .end_of_text (req_end_of_text),
      .push        (push)
   );

   // The queue flattens those bursts into one result beat per cycle unless stalled; its
   // head entry is registered, so a stalled result never blocks the input side directly.
   hstn_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .head      (head),
      .not_empty (q_not_empty),
      .full      (q_full)
   );

   assign rsp_valid    = q_not_empty;
   assign rsp_out_byte = head.data;
   assign rsp_out_last = head.last;

endmodule

### hw/rtl/hstn_check.sv
// Port-level checker for the HTML script-word neutralizer, bound to the top level.
// Depends only on the top level's ports.
module hstn_check (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_text_byte,
   input logic        req_end_of_text,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_out_last
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_out_last))
      else $error("stalled result beat changed");

   // nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // the end of a text always flushes at least one beat
   a_flush: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_end_of_text |=> rsp_valid)
      else $error("end of text produced no result");

   // input is throttled only by a backed-up queue
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with empty output");

endmodule

bind html_script_tag_neutralizer hstn_check u_hstn_check (.*);

### tb/html_script_tag_neutralizer_tb.sv
// Self-checking testbench for html_script_tag_neutralizer: text bytes in, filtered bytes out.
// Depends on hstn_pkg for the beat types and markup characters; needs nothing but the RTL.
`timescale 1ns / 100ps

module html_script_tag_neutralizer_tb;

   localparam int                 CycleLimit   = 200000;
   localparam int                 DrainLimit   = 4000;
   localparam int                 DrainSlack   = 4;
   localparam int                 HoldCycles   = 150;
   localparam logic [47:0]        WordLower    = "script";
   localparam logic [47:0]        SpanText     = " span ";
   localparam hstn_pkg::char_type LetterA      = "a";
   localparam hstn_pkg::char_type SpaceChar    = " ";

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   hstn_pkg::char_type  req_text_byte;
   logic                req_end_of_text;
   logic                rsp_valid;
   logic                rsp_stall;
   hstn_pkg::char_type  rsp_out_byte;
   logic                rsp_out_last;

   // knobs shared by the stimulus and the receiver
   bit        send_burst = 0;
   bit        rsp_eager  = 0;
   bit        rsp_hold   = 0;
   event      hold_kick;

   int        error_count = 0;
   int        cycle_count = 0;

   // expected output beats, oldest first
   hstn_pkg::beat_type  expected_beats [$];

   // shadow copy of the markup tracker and the lookahead window
   bit                  tag_open    = 0;
   bit                  quote_open  = 0;
   hstn_pkg::char_type  quote_mark  = '0;
   hstn_pkg::char_type  window_q [hstn_pkg::WinDepth];
   int                  window_count = 0;
   hstn_pkg::char_type  scan_buf [hstn_pkg::WordLen];

   html_script_tag_neutralizer DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_out_last    (rsp_out_last)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // ---------------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------------

   // Advance tag/quote tracking over one character. A quote only counts inside a tag
   // and only the same quote character closes it; '>' inside a string keeps the tag open.
   task automatic follow_markup(input hstn_pkg::char_type c);
      if (c == hstn_pkg::LtChar)
         tag_open = 1'b1;
      if (c == hstn_pkg::GtChar && tag_open && !quote_open)
         tag_open = 1'b0;
      if ((c == hstn_pkg::SqChar || c == hstn_pkg::DqChar) && tag_open) begin
         if (!quote_open) begin
            quote_mark = c;
            quote_open = 1'b1;
         end else if (c == quote_mark) begin
            quote_open = 1'b0;
         end
      end
   endtask

   // True when scan_buf spells the word from pos on, ASCII letters folded to lower case.
   function automatic bit word_at(input int pos);
      int k;
      for (k = 0; k < hstn_pkg::WordLen; k++) begin
         if ((scan_buf[pos + k] | hstn_pkg::CaseBit)
             != WordLower[8 * (hstn_pkg::WordLen - 1 - k) +: 8])
            return 1'b0;
      end
      return 1'b1;
   endfunction

   // Work out the beats that one accepted text byte releases and queue them.
   task automatic predict_filtered_beats(input hstn_pkg::char_type b, input logic eot);
      int                  n;
      int                  i;
      int                  k;
      hstn_pkg::beat_type  bt;
      n = window_count;
      for (i = 0; i < n; i++)
         scan_buf[i] = window_q[i];
      scan_buf[n] = b;
      n++;

      if (eot) begin
         // flush: decide every pending byte, a match needs all six bytes still present
         for (i = 0; i < n; i++) begin
            follow_markup(scan_buf[i]);
            if (n - i >= hstn_pkg::WordLen && tag_open && !quote_open && word_at(i)) begin
               for (k = 0; k < hstn_pkg::WordLen; k++)
                  scan_buf[i + k] = SpanText[8 * (hstn_pkg::WordLen - 1 - k) +: 8];
            end
         end
         for (i = 0; i < n; i++) begin
            bt.data = scan_buf[i];
            bt.last = (i == n - 1);
            expected_beats.push_back(bt);
         end
         // each text starts fresh
         window_count = 0;
         tag_open     = 1'b0;
         quote_open   = 1'b0;
         quote_mark   = '0;
      end else if (n < hstn_pkg::WordLen) begin
         for (i = 0; i < n; i++)
            window_q[i] = scan_buf[i];
         window_count = n;
      end else begin
         follow_markup(scan_buf[0]);
         if (tag_open && !quote_open && word_at(0)) begin
            for (k = 0; k < hstn_pkg::WordLen; k++) begin
               bt.data = SpanText[8 * (hstn_pkg::WordLen - 1 - k) +: 8];
               bt.last = 1'b0;
               expected_beats.push_back(bt);
            end
            window_count = 0;
         end else begin
            bt.data = scan_buf[0];
            bt.last = 1'b0;
            expected_beats.push_back(bt);
            for (i = 0; i < hstn_pkg::WinDepth; i++)
               window_q[i] = scan_buf[i + 1];
            window_count = hstn_pkg::WinDepth;
         end
      end
   endtask

   // ---------------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------------

   // Offer one byte beat; call at a rising edge. Valid stays high after the beat so
   // back-to-back beats need no extra edge. Stall is sampled at the falling edge,
   // where it is settled, and the beat counts as taken at the following rising edge.
   task automatic send_text_beat(input hstn_pkg::char_type b, input logic eot);
      int gap;
      bit taken;
      gap = send_burst ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_text_byte   <= b;
      req_end_of_text <= eot;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
      predict_filtered_beats(b, eot);
   endtask

   // Send a whole string, flagging its last byte when it ends the text.
   task automatic send_text(input string s, input bit ends_text);
      int i;
      for (i = 0; i < s.len(); i++)
         send_text_beat(hstn_pkg::char_type'(s[i]), ends_text && (i == s.len() - 1));
   endtask

   // Drop valid and hold until every expected beat has arrived or the drain limit
   // runs out, then let the pipeline settle.
   task automatic wait_for_results();
      int waited;
      req_valid <= 1'b0;
      for (waited = 0; waited < DrainLimit && expected_beats.size() != 0; waited++)
         @(posedge clock);
      repeat (DrainSlack) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------
   // Result side: receiver, checker and long hold-off
   // ---------------------------------------------------------------------------------

   // Decide acceptance at the falling edge, compare against the oldest expectation,
   // then drive stall for the next cycle at the rising edge.
   initial begin : result_receiver
      int                  pause_left;
      hstn_pkg::beat_type  want;
      pause_left = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (expected_beats.size() == 0) begin
               $display("%0t ns: unexpected result beat, actual byte %h last %b",
                        $time, rsp_out_byte, rsp_out_last);
               error_count++;
            end else begin
               want = expected_beats.pop_front();
               if (rsp_out_byte !== want.data) begin
                  $display("%0t ns: out_byte expected %h actual %h",
                           $time, want.data, rsp_out_byte);
                  error_count++;
               end
               if (rsp_out_last !== want.last) begin
                  $display("%0t ns: out_last expected %b actual %b",
                           $time, want.last, rsp_out_last);
                  error_count++;
               end
            end
            pause_left = rsp_eager ? 0 : $urandom_range(0, 6);
         end
         @(posedge clock);
         rsp_stall <= rsp_hold || (pause_left > 0);
         if (pause_left > 0)
            pause_left--;
      end
   end

   // Hold the result side off for a long stretch on request. Toggle on the falling
   // edge so the receiver reads a settled value at the rising edge.
   initial begin : result_hold_timer
      forever begin
         @(hold_kick);
         @(negedge clock);
         rsp_hold = 1'b1;
         repeat (HoldCycles) @(negedge clock);
         rsp_hold = 1'b0;
      end
   end

   // Guard against a hung handshake.
   initial begin : cycle_watchdog
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("TB_ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------

   // Hand-picked texts: a quote nested in the other quote with '>' inside it and a
   // mixed-case word in the tag, a short tail, a new text that must not inherit the
   // open tag, a match decided by the flush, and a single high byte.
   task automatic test_directed();
      send_burst = 1'b0;
      rsp_eager  = 1'b0;
      send_text("<\"'>\"ScRiPt>", 1'b1);
      send_text("<scrip", 1'b1);
      send_text("SCRIPT", 1'b1);
      send_text("<'a'script", 1'b1);
      send_text_beat(8'hFF, 1'b1);
      wait_for_results();
   endtask

   // Random texts built from markup tokens. Most open a tag so the word gets a chance
   // to be rewritten; the rest are noise. With pause_inside set, stop partway through
   // a text until the output has caught up, leaving bytes parked in the window.
   task automatic test_random_texts(input int byte_budget, input bit pause_inside);
      hstn_pkg::char_type  text [$];
      int                  sent;
      int                  tokens;
      int                  cut;
      int                  k;
      int                  i;
      int                  pick;
      int                  pause_at;
      sent = 0;
      while (sent < byte_budget) begin
         text.delete();
         send_burst = ($urandom_range(0, 3) == 0);
         rsp_eager  = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 3) != 0)
            text.push_back(hstn_pkg::LtChar);
         tokens = $urandom_range(1, 6);
         repeat (tokens) begin
            pick = $urandom_range(0, 11);
            if (pick < 3) begin
               // the word in random case, now and then cut short
               cut = ($urandom_range(0, 4) == 0) ?
                     $urandom_range(1, hstn_pkg::WordLen - 1) : hstn_pkg::WordLen;
               for (k = 0; k < cut; k++)
                  text.push_back(WordLower[8 * (hstn_pkg::WordLen - 1 - k) +: 8]
                                 ^ ($urandom_range(0, 1) ? hstn_pkg::CaseBit : 8'h00));
            end else begin
               case (pick)
                  3:       text.push_back(hstn_pkg::LtChar);
                  4:       text.push_back(hstn_pkg::GtChar);
                  5:       text.push_back(hstn_pkg::SqChar);
                  6:       text.push_back(hstn_pkg::DqChar);
                  7:       text.push_back(hstn_pkg::char_type'($urandom_range(1, 255)));
                  8:       text.push_back(
                              (LetterA + hstn_pkg::char_type'($urandom_range(0, 25)))
                              ^ ($urandom_range(0, 1) ? hstn_pkg::CaseBit : 8'h00));
                  9:       text.push_back(SpaceChar);
                  default: begin
                     text.push_back(hstn_pkg::LtChar);
                     text.push_back(LetterA + hstn_pkg::char_type'($urandom_range(0, 25)));
                     text.push_back(SpaceChar);
                  end
               endcase
            end
         end
         pause_at = pause_inside ? $urandom_range(0, text.size() - 1) : -1;
         for (i = 0; i < text.size(); i++) begin
            if (i == pause_at)
               wait_for_results();
            send_text_beat(text[i], i == text.size() - 1);
         end
         sent += text.size();
      end
      wait_for_results();
   endtask

   // Stall the result side for a long stretch while bytes keep coming back to back,
   // so the output queue fills and the block pushes back on its input.
   task automatic test_output_hold();
      send_burst = 1'b1;
      rsp_eager  = 1'b1;
      -> hold_kick;
      send_text("<b script='script' SCRIPTscript x=\"a'b>\" sCrIpT >out script", 1'b1);
      wait_for_results();
      send_burst = 1'b0;
      rsp_eager  = 1'b0;
   endtask

   // ---------------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------------
   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_text_byte   = '0;
      req_end_of_text = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_texts(60, 1'b0);
      test_output_hold();
      test_random_texts(20, 1'b1);
      test_random_texts(20, 1'b0);

      wait_for_results();
      if (expected_beats.size() != 0) begin
         $display("%0t ns: %0d expected beats never arrived", $time, expected_beats.size());
         error_count++;
      end
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/hstn_pkg.sv
hw/rtl/hstn_scan.sv
hw/rtl/hstn_outq.sv
hw/rtl/html_script_tag_neutralizer.sv
hw/rtl/hstn_check.sv
tb/html_script_tag_neutralizer_tb.sv
